[sv/ntdt_pkg.sv]
// Shared types and constants for the neighbor table with dead timer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ntdt_pkg;

	localparam int IP_W   = 32;
	localparam int LIVE_W = 16;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;
	localparam int SEQ_W  = 32;

	localparam logic [LIVE_W-1:0] DEFAULT_TICK_DEC = 16'd5;

	localparam logic MODE_HELLO = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic              is_new;
		logic [SLOT_W-1:0] slot;
		logic              table_full;
		logic [CNT_W-1:0]  neighbor_count;
		logic [SEQ_W-1:0]  lsa_sequence;
		logic [CNT_W-1:0]  expired_count;
	} ntdt_result_t;

endpackage

`default_nettype wire

[sv/ntdt_in_if.sv]
// Input item channel: valid/ready handshake with hello or tick payload.
// Depends on ntdt_pkg for field widths.
`default_nettype none

interface ntdt_in_if import ntdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [IP_W-1:0]   neighbor_ip;
	logic [LIVE_W-1:0] dead_interval;

	modport source (output valid, mode, neighbor_ip, dead_interval, input ready);
	modport sink   (input valid, mode, neighbor_ip, dead_interval, output ready);
endinterface

`default_nettype wire

[sv/ntdt_res_if.sv]
// Result item channel: valid/ready handshake with the result fields.
// Depends on ntdt_pkg for field widths.
`default_nettype none

interface ntdt_res_if import ntdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              is_new;
	logic [SLOT_W-1:0] slot;
	logic              table_full;
	logic [CNT_W-1:0]  neighbor_count;
	logic [SEQ_W-1:0]  lsa_sequence;
	logic [CNT_W-1:0]  expired_count;

	modport source (output valid, is_new, slot, table_full, neighbor_count,
		lsa_sequence, expired_count, input ready);
	modport sink   (input valid, is_new, slot, table_full, neighbor_count,
		lsa_sequence, expired_count, output ready);
endinterface

`default_nettype wire

[sv/ntdt_cfg_if.sv]
// Configuration write channel carrying the tick decrement register value.
// Depends on ntdt_pkg for the register width.
`default_nettype none

interface ntdt_cfg_if import ntdt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LIVE_W-1:0] tick_decrement;

	modport source (output valid, tick_decrement, input ready);
	modport sink   (input valid, tick_decrement, output ready);
endinterface

`default_nettype wire

[sv/ntdt_out_stage.sv]
// Output register for the result channel; holds one finished result.
// Depends on ntdt_pkg and ntdt_res_if.
`default_nettype none

module ntdt_out_stage
	import ntdt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire ntdt_result_t result,
	output logic              free,
	ntdt_res_if.source        res_ch
);

	logic         valid_q;
	ntdt_result_t data_q;

	assign free = !valid_q || res_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign res_ch.valid          = valid_q;
	assign res_ch.is_new         = data_q.is_new;
	assign res_ch.slot           = data_q.slot;
	assign res_ch.table_full     = data_q.table_full;
	assign res_ch.neighbor_count = data_q.neighbor_count;
	assign res_ch.lsa_sequence   = data_q.lsa_sequence;
	assign res_ch.expired_count  = data_q.expired_count;

endmodule

`default_nettype wire

[sv/neighbor_table_with_dead_timer.sv]
// Channel   Dir  Contents
// in_ch     in   mode, neighbor_ip, dead_interval (hello or tick)
// res_ch    out  is_new, slot, table_full, neighbor_count, lsa_sequence, expired_count
// cfg_ch    in   tick_decrement write data
//
// One item is taken at a time. A hello walks the address memory one entry per cycle
// until it hits, a tick walks the countdown memory one entry per cycle with a
// read-modify-write. When the walk ends, the result is loaded into the output register and
// the next input is taken once the block is back in idle; the single read port of each
// memory sets the walk speed. Reset clears the fill count, sequence number and control;
// table contents are not cleared. A stalled result sits in the output register while the
// next item is already accepted; the walk holds at its end until that register frees.
// Depends on ntdt_pkg, the channel interfaces and ntdt_out_stage.
`default_nettype none

module neighbor_table_with_dead_timer
	import ntdt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ntdt_in_if.sink   in_ch,
	ntdt_res_if.source res_ch,
	ntdt_cfg_if.sink  cfg_ch
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [LIVE_W-1:0] dec_q;
	logic [CW-1:0]     used_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     exp_q;
	logic              mode_q;
	logic [IP_W-1:0]   ip_q;
	logic [LIVE_W-1:0] dead_q;
	logic              res_new_q;
	logic              res_full_q;
	logic [IW-1:0]     res_idx_q;

	logic              pend_s1;
	logic [IW-1:0]     idx_s1;
	logic [IP_W-1:0]   addr_rd_s1;
	logic [LIVE_W-1:0] live_rd_s1;

	logic [IP_W-1:0]   addr_mem [TABLE_DEPTH];
	logic [LIVE_W-1:0] live_mem [TABLE_DEPTH];

	logic              in_xfer;
	logic              walking;
	logic              hit;
	logic              issue;
	logic              walk_end;
	logic              append;
	logic              live_we;
	logic [IW-1:0]     live_wa;
	logic [LIVE_W-1:0] live_wd;
	logic [LIVE_W-1:0] live_next;
	logic              out_free;
	logic              out_load;
	ntdt_result_t      result;
	logic [IW+SLOT_W-1:0] slot_ext;
	logic [CW+CNT_W-1:0]  used_ext;
	logic [CW+CNT_W-1:0]  exp_ext;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_xfer      = in_ch.valid && in_ch.ready;

	assign walking  = (state_q == ST_WALK);
	assign hit      = walking && pend_s1 && (mode_q == MODE_HELLO) && (addr_rd_s1 == ip_q);
	assign issue    = walking && !hit && (cnt_q < used_q);
	assign walk_end = walking && !pend_s1 && (cnt_q == used_q);
	assign append   = walk_end && (mode_q == MODE_HELLO) && (used_q != DEPTH_C);

	// Saturating countdown for the entry read last cycle.
	assign live_next = (live_rd_s1 > dec_q) ? (live_rd_s1 - dec_q) : '0;

	always_comb begin
		live_we = 1'b0;
		live_wa = idx_s1;
		live_wd = live_next;
		if (hit) begin
			live_we = 1'b1;
			live_wd = dead_q;
		end else if (walking && pend_s1 && (mode_q == MODE_TICK)) begin
			live_we = 1'b1;
		end else if (append) begin
			live_we = 1'b1;
			live_wa = used_q[IW-1:0];
			live_wd = dead_q;
		end
	end

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[live_wa] <= live_wd;
		end
		if (append) begin
			addr_mem[used_q[IW-1:0]] <= ip_q;
		end
		addr_rd_s1 <= addr_mem[cnt_q[IW-1:0]];
		live_rd_s1 <= live_mem[cnt_q[IW-1:0]];
		idx_s1     <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= in_ch.mode;
			ip_q   <= in_ch.neighbor_ip;
			dead_q <= in_ch.dead_interval;
		end
		if (hit) begin
			res_idx_q <= idx_s1;
		end else if (walk_end) begin
			res_idx_q <= append ? used_q[IW-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dec_q      <= DEFAULT_TICK_DEC;
			used_q     <= '0;
			seq_q      <= '0;
			cnt_q      <= '0;
			exp_q      <= '0;
			pend_s1    <= 1'b0;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				dec_q <= cfg_ch.tick_decrement;
			end
			pend_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (walking && pend_s1 && (mode_q == MODE_TICK) && (live_next == '0)) begin
				exp_q <= exp_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
						exp_q   <= '0;
					end
				end
				ST_WALK: begin
					if (hit) begin
						state_q    <= ST_EMIT;
						res_new_q  <= 1'b0;
						res_full_q <= 1'b0;
					end else if (walk_end) begin
						state_q    <= ST_EMIT;
						res_new_q  <= append;
						res_full_q <= (mode_q == MODE_HELLO) && !append;
						if (append) begin
							used_q <= used_q + 1'b1;
							seq_q  <= seq_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_idx_q};
	assign used_ext = {{CNT_W{1'b0}}, used_q};
	assign exp_ext  = {{CNT_W{1'b0}}, exp_q};

	always_comb begin
		result.is_new         = res_new_q;
		result.slot           = slot_ext[SLOT_W-1:0];
		result.table_full     = res_full_q;
		result.neighbor_count = used_ext[CNT_W-1:0];
		result.lsa_sequence   = seq_q;
		result.expired_count  = (mode_q == MODE_TICK) ? exp_ext[CNT_W-1:0] : '0;
	end

	assign out_load = (state_q == ST_EMIT) && out_free;

	ntdt_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.result (result),
		.free   (out_free),
		.res_ch (res_ch)
	);

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_C)
		else $error("fill count exceeds table depth");

	a_seq_with_append: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != $past(seq_q)) |-> (used_q == $past(used_q) + 1'b1))
		else $error("sequence number moved without a new neighbor");

	a_pend_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_WALK))
		else $error("memory read outstanding outside the walk");

	a_full_not_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(res_new_q && res_full_q))
		else $error("result flagged both new and table full");
`endif

endmodule

`default_nettype wire
